>>> rtl/cpa_pkg.sv
package cpa_pkg;

  localparam int TOTAL_PAGES = 256;
  localparam int MAX_REGIONS = 16;

  localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int ITER_W = $clog2(MAX_REGIONS + 1);
  localparam int PAGE_W = 8;
  localparam int CNT_W  = 9;
  localparam int ID_W   = 32;
  localparam int STS_W  = 3;
  localparam int CTR_W  = 32;

  // usable-area ceiling in pages
  localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'((TOTAL_PAGES < 256) ? TOTAL_PAGES : 256);

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STS_W-1:0] ST_NOT_FND  = 3'd2;
  localparam logic [STS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STS_W-1:0] ST_BAD      = 3'd5;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  typedef enum logic [2:0] {
    R_ERR,
    R_MOVE,
    R_GRANT,
    R_FREE,
    R_XLATE
  } reply_t;

  typedef struct packed {
    logic             load;
    logic             walk_init;
    logic             scan_step;
    logic             gap_step;
    logic             emit;
    reply_t           reply;
    logic [STS_W-1:0] err_status;
  } cpa_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       need_zero;
    logic       hit;
    logic       slot_free;
    logic       page_oob;
    logic       idx_last;
    logic       more;
    logic       fit;
    logic       need_gt_total;
    logic       multi_run;
    logic       target_hit;
    logic       out_free;
  } cpa_sts_t;

endpackage

>>> rtl/cpa_if.sv
interface cpa_req_if import cpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [ID_W-1:0]   proc_id;
  logic [CNT_W-1:0]  amount;
  modport source (output valid, func, proc_id, amount, input ready);
  modport sink   (input valid, func, proc_id, amount, output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic              kind;
  logic [PAGE_W-1:0] page_addr;
  logic [PAGE_W-1:0] move_source;
  logic [CNT_W-1:0]  move_count;
  logic [CTR_W-1:0]  reads_done;
  logic [CTR_W-1:0]  writes_done;
  logic              last;
  modport source (output valid, status, kind, page_addr, move_source, move_count,
                  reads_done, writes_done, last, input ready);
  modport sink   (input valid, status, kind, page_addr, move_source, move_count,
                  reads_done, writes_done, last, output ready);
endinterface

interface cpa_cfg_if import cpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/cpa_datapath.sv
module cpa_datapath import cpa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cpa_req_if.sink       req,
  cpa_rsp_if.source     rsp,
  cpa_cfg_if.sink       cfg,
  input  cpa_cmd_t      cmd,
  output cpa_sts_t      sts
);

  logic [CNT_W-1:0] pages;
  logic [CNT_W-1:0] lim;

  logic [1:0]        func;
  logic [ID_W-1:0]   pid;
  logic [CNT_W-1:0]  need;

  logic              r_valid  [MAX_REGIONS];
  logic [ID_W-1:0]   r_owner  [MAX_REGIONS];
  logic [PAGE_W-1:0] r_base   [MAX_REGIONS];
  logic [CNT_W-1:0]  r_len    [MAX_REGIONS];
  logic [CTR_W-1:0]  r_reads  [MAX_REGIONS];
  logic [CTR_W-1:0]  r_writes [MAX_REGIONS];

  // walk state
  logic [CNT_W-1:0]  cur;
  logic [IDX_W-1:0]  idx;
  logic              best_found;
  logic [PAGE_W-1:0] best_base;
  logic [CNT_W-1:0]  best_end;
  logic [1:0]        run_cnt;
  logic [PAGE_W-1:0] first_start;
  logic [CNT_W-1:0]  first_end;
  logic              fit;
  logic [PAGE_W-1:0] fit_base;
  logic [CNT_W-1:0]  total;

  logic              out_valid;

  logic              hit, slot_free, tgt_hit;
  logic [IDX_W-1:0]  hit_idx, slot_idx, tgt_idx;

  always_comb begin
    hit = 1'b0; slot_free = 1'b0; tgt_hit = 1'b0;
    hit_idx = '0; slot_idx = '0; tgt_idx = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (r_valid[i] && r_owner[i] == pid) begin
        hit = 1'b1; hit_idx = IDX_W'(i);
      end
      if (!r_valid[i]) begin
        slot_free = 1'b1; slot_idx = IDX_W'(i);
      end
      if (r_valid[i] && {1'b0, r_base[i]} == first_end) begin
        tgt_hit = 1'b1; tgt_idx = IDX_W'(i);
      end
    end
  end

  logic [CNT_W-1:0] ent_base, ent_end, hi, run_len;
  logic             ent_take, run_ok;

  always_comb begin
    ent_base = {1'b0, r_base[idx]};
    ent_end  = ent_base + r_len[idx];
    ent_take = r_valid[idx] && ent_base >= cur && (!best_found || r_base[idx] < best_base);
    if (best_found) hi = ({1'b0, best_base} < lim) ? {1'b0, best_base} : lim;
    else            hi = lim;
    run_ok  = hi > cur;
    run_len = hi - cur;
  end

  assign lim = (pages > LIM_MAX) ? LIM_MAX : pages;
  assign cfg.ready = 1'b1;
  assign req.ready = cmd.load;

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    sts.func          = func;
    sts.need_zero     = need == '0;
    sts.hit           = hit;
    sts.slot_free     = slot_free;
    sts.page_oob      = need >= r_len[hit_idx];
    sts.idx_last      = idx == IDX_W'(MAX_REGIONS - 1);
    sts.more          = best_found;
    sts.fit           = fit;
    sts.need_gt_total = need > total;
    sts.multi_run     = run_cnt > 2'd1;
    sts.target_hit    = tgt_hit;
    sts.out_free      = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages     <= CNT_W'(256);
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) r_valid[i] <= 1'b0;
    end else begin
      if (cfg.valid) pages <= cfg.data;

      if (cmd.load) begin
        func <= req.func;
        pid  <= req.proc_id;
        need <= req.amount;
      end

      if (cmd.walk_init) begin
        cur        <= '0;
        idx        <= '0;
        best_found <= 1'b0;
        run_cnt    <= '0;
        fit        <= 1'b0;
        total      <= '0;
      end

      if (cmd.scan_step) begin
        if (ent_take) begin
          best_found <= 1'b1;
          best_base  <= r_base[idx];
          best_end   <= ent_end;
        end
        idx <= (idx == IDX_W'(MAX_REGIONS - 1)) ? '0 : idx + 1'b1;
      end

      if (cmd.gap_step) begin
        if (run_ok) begin
          if (run_cnt == 2'd0) begin
            first_start <= cur[PAGE_W-1:0];
            first_end   <= hi;
          end
          if (run_cnt != 2'd2) run_cnt <= run_cnt + 1'b1;
          total <= total + run_len;
          if (!fit && run_len >= need) begin
            fit      <= 1'b1;
            fit_base <= cur[PAGE_W-1:0];
          end
        end
        if (best_found) cur <= best_end;
        best_found <= 1'b0;
      end

      if (rsp.valid && rsp.ready) out_valid <= 1'b0;

      if (cmd.emit) begin
        out_valid       <= 1'b1;
        rsp.status      <= ST_OK;
        rsp.kind        <= KIND_REPLY;
        rsp.page_addr   <= '0;
        rsp.move_source <= '0;
        rsp.move_count  <= '0;
        rsp.reads_done  <= '0;
        rsp.writes_done <= '0;
        rsp.last        <= 1'b1;
        unique case (cmd.reply)
          R_ERR: rsp.status <= cmd.err_status;
          R_MOVE: begin
            rsp.kind        <= KIND_MOVE;
            rsp.last        <= 1'b0;
            rsp.page_addr   <= first_start;
            rsp.move_source <= r_base[tgt_idx];
            rsp.move_count  <= r_len[tgt_idx];
            r_base[tgt_idx] <= first_start;
          end
          R_GRANT: begin
            rsp.page_addr       <= fit_base;
            r_valid[slot_idx]   <= 1'b1;
            r_owner[slot_idx]   <= pid;
            r_base[slot_idx]    <= fit_base;
            r_len[slot_idx]     <= need;
            r_reads[slot_idx]   <= '0;
            r_writes[slot_idx]  <= '0;
          end
          R_FREE: begin
            rsp.page_addr    <= r_base[hit_idx];
            rsp.reads_done   <= r_reads[hit_idx];
            rsp.writes_done  <= r_writes[hit_idx];
            r_valid[hit_idx] <= 1'b0;
          end
          R_XLATE: begin
            rsp.page_addr <= r_base[hit_idx] + need[PAGE_W-1:0];
            if (func == FUNC_READ) begin
              if (r_reads[hit_idx] != '1) r_reads[hit_idx] <= r_reads[hit_idx] + 1'b1;
            end else begin
              if (r_writes[hit_idx] != '1) r_writes[hit_idx] <= r_writes[hit_idx] + 1'b1;
            end
          end
          default: rsp.status <= ST_BAD;
        endcase
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

>>> rtl/cpa_ctrl.sv
module cpa_ctrl import cpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  cpa_sts_t sts,
  output cpa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_GAP, S_A_CHECK, S_C_CHECK, S_F_CHECK
  } state_t;

  state_t state, state_next, ret, ret_next;
  logic [ITER_W-1:0] iter, iter_next;

  always_comb begin
    cmd        = '0;
    cmd.reply  = R_ERR;
    state_next = state;
    ret_next   = ret;
    iter_next  = iter;
    unique case (state)
      S_IDLE: begin
        cmd.load = 1'b1;
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.func == FUNC_ALLOC) begin
          if (sts.need_zero || sts.hit) begin
            cmd.emit = sts.out_free; cmd.err_status = ST_BAD;
          end else if (!sts.slot_free) begin
            cmd.emit = sts.out_free; cmd.err_status = ST_FULL;
          end else begin
            cmd.walk_init = 1'b1;
            ret_next      = S_A_CHECK;
            state_next    = S_SCAN;
          end
        end else if (!sts.hit) begin
          cmd.emit = sts.out_free; cmd.err_status = ST_NOT_FND;
        end else if (sts.func == FUNC_FREE) begin
          cmd.emit = sts.out_free; cmd.reply = R_FREE;
        end else if (sts.page_oob) begin
          cmd.emit = sts.out_free; cmd.err_status = ST_RANGE;
        end else begin
          cmd.emit = sts.out_free; cmd.reply = R_XLATE;
        end
        if (cmd.emit) state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_next = S_GAP;
      end
      S_GAP: begin
        cmd.gap_step = 1'b1;
        state_next   = sts.more ? S_SCAN : ret;
      end
      S_A_CHECK: begin
        if (sts.fit) begin
          cmd.emit = sts.out_free; cmd.reply = R_GRANT;
          if (cmd.emit) state_next = S_IDLE;
        end else if (sts.need_gt_total) begin
          cmd.emit = sts.out_free; cmd.err_status = ST_NO_SPACE;
          if (cmd.emit) state_next = S_IDLE;
        end else begin
          iter_next     = '0;
          cmd.walk_init = 1'b1;
          ret_next      = S_C_CHECK;
          state_next    = S_SCAN;
        end
      end
      S_C_CHECK: begin
        if (sts.multi_run && sts.target_hit) begin
          cmd.emit = sts.out_free; cmd.reply = R_MOVE;
          if (cmd.emit) begin
            iter_next     = iter + 1'b1;
            cmd.walk_init = 1'b1;
            ret_next      = (iter_next == ITER_W'(MAX_REGIONS)) ? S_F_CHECK : S_C_CHECK;
            state_next    = S_SCAN;
          end
        end else begin
          // table unchanged since this walk, its fit result stands
          state_next = S_F_CHECK;
        end
      end
      S_F_CHECK: begin
        cmd.emit = sts.out_free;
        if (sts.fit) cmd.reply = R_GRANT;
        else         cmd.err_status = ST_NO_SPACE;
        if (cmd.emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_A_CHECK;
      iter  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      iter  <= iter_next;
    end
  end

endmodule

>>> rtl/contiguous_page_allocator_top.sv
// channel | dir | beat contents
// req     | in  | func, proc_id, amount
// rsp     | out | status, kind, page_addr, move_source, move_count,
//         |     | reads_done, writes_done, last
// cfg     | in  | data = pages_in_use
//
// Sequencing: free/read/write pass through idle and decode, then wait on the
//   output. Allocate adds a table walk that scans every region entry once per
//   region passed plus once more; compaction repeats the walk once, then runs
//   one walk per move, up to MAX_REGIONS moves.
//   The walk scans the region table one entry at a time.
// Reset: synchronous, clears the region valid bits and sets pages_in_use to 256.
// Stalls: the output register frees req while a beat waits on rsp; a new beat
//   is emitted only when the register is empty or its beat is taken that cycle.
module contiguous_page_allocator_top import cpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cpa_req_if.sink   req,
  cpa_rsp_if.source rsp,
  cpa_cfg_if.sink   cfg
);

  cpa_cmd_t cmd;
  cpa_sts_t sts;

  // sequencer: decode, walks, compaction loop
  cpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // region table, walk registers, output register
  cpa_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

>>> rtl/cpa_checker.sv
module cpa_checker import cpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STS_W-1:0]  rsp_status,
  input logic              rsp_kind,
  input logic [PAGE_W-1:0] rsp_page_addr,
  input logic [CTR_W-1:0]  rsp_reads_done,
  input logic              rsp_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_addr) && $stable(rsp_last))
    else $error("rsp beat changed while stalled");

  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_MOVE |-> !rsp_last && rsp_status == ST_OK)
    else $error("move beat flagged last or with error");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_REPLY |-> rsp_last)
    else $error("final reply without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_page_addr == '0 && rsp_reads_done == '0)
    else $error("error reply carries data");

endmodule

bind contiguous_page_allocator_top cpa_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_kind       (rsp.kind),
  .rsp_page_addr  (rsp.page_addr),
  .rsp_reads_done (rsp.reads_done),
  .rsp_last       (rsp.last)
);

>>> test/tb_contiguous_page_allocator_top.sv
module tb_contiguous_page_allocator_top;
  import cpa_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  cpa_req_if req ();
  cpa_rsp_if rsp ();
  cpa_cfg_if cfg ();

  contiguous_page_allocator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  // one response beat as compared against the allocator model
  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              kind;
    logic [PAGE_W-1:0] page_addr;
    logic [PAGE_W-1:0] move_source;
    logic [CNT_W-1:0]  move_count;
    logic [CTR_W-1:0]  reads_done;
    logic [CTR_W-1:0]  writes_done;
    logic              last;
  } beat_t;

  typedef struct {
    logic [1:0]       func;
    logic [ID_W-1:0]  proc_id;
    logic [CNT_W-1:0] amount;
    bit               typed;     // expected reply typed into the table
    logic [STS_W-1:0] t_status;
    logic [PAGE_W-1:0] t_addr;
  } row_t;

  // allocator model state
  int unsigned area_pages;
  bit          slot_used [MAX_REGIONS];
  int unsigned slot_pid  [MAX_REGIONS];
  int unsigned slot_base [MAX_REGIONS];
  int unsigned slot_len  [MAX_REGIONS];
  int unsigned slot_rd   [MAX_REGIONS];
  int unsigned slot_wr   [MAX_REGIONS];

  beat_t pending_beats[$];
  int    errors;
  int    shown;
  int    ncycles;
  bit    quiet;        // no idling in the last part of the run
  bit    rx_hold;      // long receiver hold-off
  int    n_rsp_seen;

  // ---------------- model ----------------
  function automatic beat_t mk(logic [STS_W-1:0] s, logic k, int unsigned a,
                               int unsigned src, int unsigned c,
                               int unsigned rd, int unsigned wr, logic l);
    beat_t b;
    b.status = s; b.kind = k; b.page_addr = a[7:0]; b.move_source = src[7:0];
    b.move_count = c[8:0]; b.reads_done = rd; b.writes_done = wr; b.last = l;
    return b;
  endfunction

  function automatic int unsigned area_limit();
    int unsigned l;
    l = area_pages;
    if (l > TOTAL_PAGES) l = TOTAL_PAGES;
    if (l > 256) l = 256;
    return l;
  endfunction

  // free gaps in address order
  function automatic int gaps(output int unsigned gs[$], output int unsigned gl[$]);
    int ord[$];
    int unsigned cur, lim, b, e, hi;
    int j;
    gs = {}; gl = {};
    lim = area_limit();
    cur = 0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (!slot_used[i]) continue;
      j = ord.size();
      ord.push_back(i);
      while (j > 0 && slot_base[ord[j-1]] > slot_base[i]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = i;
    end
    foreach (ord[k]) begin
      b = slot_base[ord[k]];
      e = b + slot_len[ord[k]];
      if (b > cur) begin
        hi = (b < lim) ? b : lim;
        if (hi > cur) begin gs.push_back(cur); gl.push_back(hi - cur); end
      end
      if (e > cur) cur = e;
    end
    if (lim > cur) begin gs.push_back(cur); gl.push_back(lim - cur); end
    return gs.size();
  endfunction

  function automatic int owner_slot(int unsigned pid);
    for (int i = 0; i < MAX_REGIONS; i++)
      if (slot_used[i] && slot_pid[i] == pid) return i;
    return -1;
  endfunction

  function automatic bit fit(int unsigned need, output int unsigned base);
    int unsigned gs[$], gl[$];
    void'(gaps(gs, gl));
    base = 0;
    foreach (gs[i]) if (gl[i] >= need) begin base = gs[i]; return 1; end
    return 0;
  endfunction

  function automatic void predict_alloc(int unsigned pid, int unsigned need);
    int unsigned gs[$], gl[$];
    int unsigned base, total, tgt;
    int slot, r;
    if (need == 0 || owner_slot(pid) >= 0) begin
      pending_beats.push_back(mk(ST_BAD, KIND_REPLY, 0, 0, 0, 0, 0, 1));
      return;
    end
    slot = -1;
    for (int i = 0; i < MAX_REGIONS; i++) if (!slot_used[i]) begin slot = i; break; end
    if (slot < 0) begin
      pending_beats.push_back(mk(ST_FULL, KIND_REPLY, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (!fit(need, base)) begin
      void'(gaps(gs, gl));
      total = 0;
      foreach (gl[i]) total += gl[i];
      if (need > total) begin
        pending_beats.push_back(mk(ST_NO_SPACE, KIND_REPLY, 0, 0, 0, 0, 0, 1));
        return;
      end
      // compaction: slide the region above the lowest gap down onto it
      for (int it = 0; it < MAX_REGIONS; it++) begin
        if (gaps(gs, gl) <= 1) break;
        tgt = gs[0] + gl[0];
        r = -1;
        for (int i = 0; i < MAX_REGIONS; i++)
          if (slot_used[i] && slot_base[i] == tgt) begin r = i; break; end
        if (r < 0) break;
        pending_beats.push_back(mk(ST_OK, KIND_MOVE, gs[0], slot_base[r], slot_len[r],
                                   0, 0, 0));
        slot_base[r] = gs[0];
      end
      if (!fit(need, base)) begin
        pending_beats.push_back(mk(ST_NO_SPACE, KIND_REPLY, 0, 0, 0, 0, 0, 1));
        return;
      end
    end
    slot_used[slot] = 1; slot_pid[slot] = pid; slot_base[slot] = base;
    slot_len[slot] = need & 9'h1FF; slot_rd[slot] = 0; slot_wr[slot] = 0;
    pending_beats.push_back(mk(ST_OK, KIND_REPLY, base, 0, 0, 0, 0, 1));
  endfunction

  function automatic void predict_request(logic [1:0] f, int unsigned pid,
                                          int unsigned amt);
    int r;
    if (f == FUNC_ALLOC) begin predict_alloc(pid, amt); return; end
    r = owner_slot(pid);
    if (r < 0) begin
      pending_beats.push_back(mk(ST_NOT_FND, KIND_REPLY, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (f == FUNC_FREE) begin
      slot_used[r] = 0;
      pending_beats.push_back(mk(ST_OK, KIND_REPLY, slot_base[r], 0, 0,
                                 slot_rd[r], slot_wr[r], 1));
      return;
    end
    if (amt >= slot_len[r]) begin
      pending_beats.push_back(mk(ST_RANGE, KIND_REPLY, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (f == FUNC_READ) begin
      if (slot_rd[r] != 32'hFFFF_FFFF) slot_rd[r]++;
    end else begin
      if (slot_wr[r] != 32'hFFFF_FFFF) slot_wr[r]++;
    end
    pending_beats.push_back(mk(ST_OK, KIND_REPLY, slot_base[r] + amt, 0, 0, 0, 0, 1));
  endfunction

  // ---------------- drivers ----------------
  initial begin
    req.valid = 1'b0; req.func = FUNC_ALLOC; req.proc_id = '0; req.amount = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    rsp.ready = 1'b0;
  end

  // valid drops only when a gap follows
  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // send one request beat; the model is updated on acceptance
  task automatic send_req(logic [1:0] f, logic [ID_W-1:0] pid, logic [CNT_W-1:0] amt);
    idle_burst();
    req.valid   <= 1'b1;
    req.func    <= f;
    req.proc_id <= pid;
    req.amount  <= amt;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_request(f, pid, 32'(amt));
  endtask

  // wait until the block has drained, then write pages_in_use
  task automatic write_area(logic [CNT_W-1:0] v);
    req.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    area_pages = 32'(v);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      rsp.ready <= 1'b0;
    end else if (quiet) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 4) != 0);
    end
  end

  // burst-shaped stalls come from short random runs of low ready above;
  // the long hold-off is its own process
  initial begin
    rx_hold = 1'b0;
    wait (n_rsp_seen >= 40);
    rx_hold = 1'b1;
    repeat (600) @(posedge clk);
    rx_hold = 1'b0;
  end

  // typed expectation for directed rows (checked in addition to the model)
  logic [STS_W-1:0]  typed_status[$];
  logic [PAGE_W-1:0] typed_addr[$];
  bit                typed_on[$];

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      n_rsp_seen <= n_rsp_seen + 1;
      got.status = rsp.status; got.kind = rsp.kind; got.page_addr = rsp.page_addr;
      got.move_source = rsp.move_source; got.move_count = rsp.move_count;
      got.reads_done = rsp.reads_done; got.writes_done = rsp.writes_done;
      got.last = rsp.last;
      if (pending_beats.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected rsp beat %h", got);
        end
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("rsp mismatch: exp st=%0d k=%0d pa=%0d src=%0d cnt=%0d rd=%0d wr=%0d l=%0d",
                     want.status, want.kind, want.page_addr, want.move_source,
                     want.move_count, want.reads_done, want.writes_done, want.last);
            $display("              got st=%0d k=%0d pa=%0d src=%0d cnt=%0d rd=%0d wr=%0d l=%0d",
                     got.status, got.kind, got.page_addr, got.move_source,
                     got.move_count, got.reads_done, got.writes_done, got.last);
          end
        end
        // final reply of a directed row with a typed result
        if (got.last && typed_on.size() != 0) begin
          if (typed_on.pop_front() &&
              (got.status !== typed_status[0] || got.page_addr !== typed_addr[0])) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("directed row: exp st=%0d pa=%0d got st=%0d pa=%0d",
                       typed_status[0], typed_addr[0], got.status, got.page_addr);
            end
          end
          void'(typed_status.pop_front());
          void'(typed_addr.pop_front());
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    ncycles <= ncycles + 1;
    if (ncycles > 2000000) begin
      $display("tb_contiguous_page_allocator_top: errors");
      $finish;
    end
  end

  // directed stimulus table; typed results only where obvious
  row_t plan[$];

  function automatic row_t row(logic [1:0] f, logic [ID_W-1:0] p, logic [CNT_W-1:0] a,
                               bit t = 0, logic [STS_W-1:0] s = ST_OK,
                               logic [PAGE_W-1:0] pa = '0);
    row_t r;
    r.func = f; r.proc_id = p; r.amount = a; r.typed = t; r.t_status = s; r.t_addr = pa;
    return r;
  endfunction

  task automatic run_row(row_t r);
    typed_on.push_back(r.typed);
    typed_status.push_back(r.t_status);
    typed_addr.push_back(r.t_addr);
    send_req(r.func, r.proc_id, r.amount);
  endtask

  task automatic random_phase(int n, int unsigned pid_span);
    int unsigned p, a, pick;
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      p = $urandom_range(1, pid_span);
      if (pick < 5) p = $urandom;                      // noise pid
      if (pick < 40) begin
        f = FUNC_ALLOC;
        a = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 40);
      end else if (pick < 60) begin
        f = FUNC_FREE; a = $urandom_range(0, 511);
      end else begin
        f = $urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE;
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 20);
      end
      typed_on.push_back(0); typed_status.push_back(ST_OK); typed_addr.push_back('0);
      send_req(f, p, CNT_W'(a));
    end
  endtask

  initial begin
    errors = 0; shown = 0; ncycles = 0; n_rsp_seen = 0; quiet = 0;
    area_pages = 256;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      slot_used[i] = 0; slot_pid[i] = 0; slot_base[i] = 0;
      slot_len[i] = 0; slot_rd[i] = 0; slot_wr[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: empty table, first grant at page 0
    plan.push_back(row(FUNC_READ,  32'h0,         9'd0,   1, ST_NOT_FND));
    plan.push_back(row(FUNC_ALLOC, 32'hFFFF_FFFF, 9'd0,   1, ST_BAD));     // zero pages
    plan.push_back(row(FUNC_ALLOC, 32'hFFFF_FFFF, 9'd257, 1, ST_NO_SPACE));
    plan.push_back(row(FUNC_ALLOC, 32'hFFFF_FFFF, 9'd10,  1, ST_OK, 8'd0));
    plan.push_back(row(FUNC_ALLOC, 32'hFFFF_FFFF, 9'd3,   1, ST_BAD));     // duplicate pid
    plan.push_back(row(FUNC_ALLOC, 32'h0,         9'd20,  1, ST_OK, 8'd10));
    plan.push_back(row(FUNC_ALLOC, 32'h5555_AAAA, 9'd5,   1, ST_OK, 8'd30));
    plan.push_back(row(FUNC_WRITE, 32'h0,         9'd19,  1, ST_OK, 8'd29));
    plan.push_back(row(FUNC_WRITE, 32'h0,         9'd20,  1, ST_RANGE));
    plan.push_back(row(FUNC_READ,  32'hFFFF_FFFF, 9'd9,   1, ST_OK, 8'd9));
    plan.push_back(row(FUNC_READ,  32'hFFFF_FFFF, 9'd511, 1, ST_RANGE));
    plan.push_back(row(FUNC_FREE,  32'h0,         9'd0));                  // counts via model
    plan.push_back(row(FUNC_FREE,  32'h1234_5678, 9'd0,   1, ST_NOT_FND));
    plan.push_back(row(FUNC_ALLOC, 32'h7,         9'd222));                // forces compaction
    plan.push_back(row(FUNC_ALLOC, 32'h8,         9'd20));                 // no space left
    plan.push_back(row(FUNC_FREE,  32'hFFFF_FFFF, 9'd0));
    plan.push_back(row(FUNC_FREE,  32'h5555_AAAA, 9'd0));
    plan.push_back(row(FUNC_FREE,  32'h7,         9'd0));
    for (int i = 0; i < 16; i++) plan.push_back(row(FUNC_ALLOC, i + 100, 9'd1));
    plan.push_back(row(FUNC_ALLOC, 32'd200,       9'd1,   1, ST_FULL));    // table full
    foreach (plan[i]) run_row(plan[i]);
    for (int i = 0; i < 16; i++) begin
      typed_on.push_back(0); typed_status.push_back(ST_OK); typed_addr.push_back('0);
      send_req(FUNC_FREE, i + 100, 9'd0);
    end

    // extreme setting: no usable pages
    write_area(9'd0);
    run_row(row(FUNC_ALLOC, 32'd1, 9'd1, 1, ST_NO_SPACE));
    write_area(9'd1);
    run_row(row(FUNC_ALLOC, 32'd1, 9'd1, 1, ST_OK, 8'd0));
    run_row(row(FUNC_ALLOC, 32'd2, 9'd1, 1, ST_NO_SPACE));

    // random phases over several area sizes; small pid span forces collisions
    write_area(9'd64);
    random_phase(15, 12);
    write_area(9'd511);          // clipped to the full area
    random_phase(15, 20);
    write_area(CNT_W'($urandom_range(1, 200)));
    random_phase(10, 10);

    // last part: no idling anywhere
    req.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    quiet = 1;
    random_phase(10, 10);

    req.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("tb_contiguous_page_allocator_top: clean");
    end else begin
      $display("tb_contiguous_page_allocator_top: errors");
    end
    $finish;
  end

endmodule
